// ===== hdl/lane_priority_job_queue_core_defines.svh =====
// Assertion macros for the checker file of the job queue.
`ifndef LANE_PRIORITY_JOB_QUEUE_CORE_DEFINES_SVH
`define LANE_PRIORITY_JOB_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LPJQ_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("job queue assertion failed");

// Next-cycle implication, checked outside reset.
`define LPJQ_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("job queue assertion failed");

`endif

// ===== hdl/lpjq_pkg.sv =====
package lpjq_pkg;

  // Operation classes handed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_ENQ,
    OP_DEQ,
    OP_SET,
    OP_QRY,
    OP_STOP,
    OP_BAD
  } op_t;

  // Input mode codes.
  localparam logic [2:0] MODE_ENQ  = 3'd0;
  localparam logic [2:0] MODE_DEQ  = 3'd1;
  localparam logic [2:0] MODE_SET  = 3'd2;
  localparam logic [2:0] MODE_QRY  = 3'd3;
  localparam logic [2:0] MODE_STOP = 3'd4;

  // Job states.
  localparam logic [2:0] JS_QUEUED   = 3'd0;
  localparam logic [2:0] JS_RUNNING  = 3'd1;
  localparam logic [2:0] JS_DONE     = 3'd2;
  localparam logic [2:0] JS_FAILED   = 3'd3;
  localparam logic [2:0] JS_CANCELED = 3'd4;

  // Result status codes.
  localparam logic [1:0] RSP_OK    = 2'd0;
  localparam logic [1:0] RSP_FAIL  = 2'd1;
  localparam logic [1:0] RSP_EMPTY = 2'd2;

  localparam logic [31:0] RESULT_FAIL = 32'hFFFF_FFFF;
  localparam int unsigned CMDQ_DEPTH = 2;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DQRD,
    ST_MATCH,
    ST_ENC,
    ST_RMW
  } st_t;

  // Classified request.
  typedef struct packed {
    op_t         op;
    logic [2:0]  lane;
    logic        prio;
    logic [7:0]  unit;
    logic [7:0]  command;
    logic [31:0] op_id;
    logic [2:0]  new_state;
    logic [31:0] new_result;
    logic [31:0] now_ms;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] op_id;
    logic [2:0]  lane;
    logic [7:0]  unit;
    logic [7:0]  command;
    logic [2:0]  state;
    logic [31:0] result;
    logic [31:0] created_ms;
    logic [31:0] started_ms;
    logic [31:0] ended_ms;
  } rsp_t;

  // Status table entry, without the id.
  typedef struct packed {
    logic [2:0]  lane;
    logic [7:0]  unit;
    logic [7:0]  command;
    logic [2:0]  state;
    logic [31:0] result;
    logic [31:0] created_ms;
    logic [31:0] started_ms;
    logic [31:0] ended_ms;
  } entry_t;

  // FIFO word: id, unit, command.
  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  unit;
    logic [7:0]  command;
  } job_t;

  // Queue handshake between front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hdl/lpjq_front.sv =====
module lpjq_front #(
  parameter int unsigned LANE_COUNT = 4
) (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_mode,
  input  logic [2:0]        in_lane,
  input  logic              in_prio,
  input  logic [7:0]        in_unit,
  input  logic [7:0]        in_command,
  input  logic [31:0]       in_op_id,
  input  logic [2:0]        in_new_state,
  input  logic signed [31:0] in_new_result,
  input  logic [31:0]       in_now_ms,
  input  lpjq_pkg::q_stat_t q_stat,
  output logic              push,
  output lpjq_pkg::cmd_t    push_cmd
);
  import lpjq_pkg::*;

  logic lane_ok;

  // For enqueue, dequeue and stop, a lane number at or above the lane count is rejected.
  assign lane_ok = ({1'b0, in_lane} < 4'(LANE_COUNT));

  // The input stalls only when the command queue is full.
  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  // Classify the request and carry its fields.
  always_comb begin
    push_cmd            = '0;
    push_cmd.lane       = in_lane;
    push_cmd.prio       = in_prio;
    push_cmd.unit       = in_unit;
    push_cmd.command    = in_command;
    push_cmd.op_id      = in_op_id;
    push_cmd.new_state  = in_new_state;
    push_cmd.new_result = in_new_result;
    push_cmd.now_ms     = in_now_ms;
    case (in_mode)
      MODE_ENQ:  push_cmd.op = lane_ok ? OP_ENQ : OP_BAD;
      MODE_DEQ:  push_cmd.op = lane_ok ? OP_DEQ : OP_BAD;
      MODE_SET:  push_cmd.op = (in_new_state <= JS_CANCELED) ? OP_SET : OP_BAD;
      MODE_QRY:  push_cmd.op = OP_QRY;
      MODE_STOP: push_cmd.op = lane_ok ? OP_STOP : OP_BAD;
      default:   push_cmd.op = OP_BAD;
    endcase
  end

endmodule

// ===== hdl/lpjq_cmdq.sv =====
module lpjq_cmdq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  lpjq_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output lpjq_pkg::cmd_t    pop_cmd,
  output lpjq_pkg::q_stat_t q_stat
);
  import lpjq_pkg::*;

  localparam int unsigned PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned CW = $clog2(CMDQ_DEPTH + 1);

  cmd_t          slot_r [CMDQ_DEPTH];
  logic [PW-1:0] wr_r, wr_nxt;
  logic [PW-1:0] rd_r, rd_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign q_stat.full  = (cnt_r == CW'(CMDQ_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_cmd      = slot_r[rd_r];

  // Pointer and count bookkeeping.
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_r] <= push_cmd;
    end
  end

endmodule

// ===== hdl/lpjq_back.sv =====
module lpjq_back #(
  parameter int unsigned LANE_COUNT  = 4,
  parameter int unsigned HIGH_DEPTH  = 8,
  parameter int unsigned LOW_DEPTH   = 16,
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  lpjq_pkg::q_stat_t q_stat,
  input  lpjq_pkg::cmd_t    pop_cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output lpjq_pkg::rsp_t    out_rsp
);
  import lpjq_pkg::*;

  localparam int unsigned LW  = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
  localparam int unsigned HW  = (HIGH_DEPTH > 1) ? $clog2(HIGH_DEPTH) : 1;
  localparam int unsigned LOW = (LOW_DEPTH > 1) ? $clog2(LOW_DEPTH) : 1;
  localparam int unsigned HCW = $clog2(HIGH_DEPTH + 1);
  localparam int unsigned LCW = $clog2(LOW_DEPTH + 1);
  localparam int unsigned TW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned HMD = LANE_COUNT * (2 ** HW);
  localparam int unsigned LMD = LANE_COUNT * (2 ** LOW);

  // Sequencer and item.
  st_t           state_r, state_nxt;
  cmd_t          cur_r;
  logic [LW-1:0] li;

  // Lane pointers and stop flags.
  logic [HW-1:0]  hhead_r [LANE_COUNT];
  logic [HCW-1:0] hcnt_r  [LANE_COUNT];
  logic [LOW-1:0] lhead_r [LANE_COUNT];
  logic [LCW-1:0] lcnt_r  [LANE_COUNT];
  logic           stop_r  [LANE_COUNT];

  // FIFO memories.
  job_t           hmem [HMD];
  job_t           lmem [LMD];
  job_t           hrd_r, lrd_r, word_r;
  logic           from_hi_r;

  // Status table: ids in registers for the parallel compare, the rest in memory.
  logic [31:0]      ids_r [TABLE_DEPTH];
  logic             idv_r [TABLE_DEPTH];
  entry_t           tmem  [TABLE_DEPTH];
  entry_t           trd_r;
  logic [TABLE_DEPTH-1:0] match_r;
  logic [TW-1:0]    slot_r, enc_slot, ins_r;
  logic             found_r, enc_found;
  logic [31:0]      key_r;
  logic [31:0]      next_id_r;

  // Output register.
  logic out_valid_r;
  rsp_t out_rsp_r;
  logic out_free;

  // Control from the output decode.
  logic   do_enq, do_deq_rd, do_stop, do_load_out, do_rmw_wr;
  rsp_t   rsp_new;

  // Enqueue datapath.
  logic [31:0]     enq_id;
  logic            enq_stopped, enq_full;
  logic [HCW:0]    htail_sum;
  logic [LCW:0]    ltail_sum;
  logic [HW-1:0]   htail;
  logic [LOW-1:0]  ltail;
  logic            deq_empty;
  entry_t          tab_wd;
  logic [TW-1:0]   tab_wa;
  logic            tab_we;
  logic [2:0]      set_st;
  logic [31:0]     set_res;

  assign li        = cur_r.lane[LW-1:0];
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign enq_id      = (next_id_r == '0) ? 32'd1 : next_id_r;
  assign enq_stopped = stop_r[li];
  assign enq_full    = cur_r.prio ? (hcnt_r[li] == HCW'(HIGH_DEPTH))
                                  : (lcnt_r[li] == LCW'(LOW_DEPTH));
  assign deq_empty   = (hcnt_r[li] == '0) && (lcnt_r[li] == '0);

  // Ring tails: head plus count, folded once at the depth.
  assign htail_sum = {1'b0, HCW'(hhead_r[li])} + {1'b0, hcnt_r[li]};
  assign ltail_sum = {1'b0, LCW'(lhead_r[li])} + {1'b0, lcnt_r[li]};
  assign htail = (htail_sum >= (HCW + 1)'(HIGH_DEPTH))
               ? HW'(htail_sum - (HCW + 1)'(HIGH_DEPTH)) : HW'(htail_sum);
  assign ltail = (ltail_sum >= (LCW + 1)'(LOW_DEPTH))
               ? LOW'(ltail_sum - (LCW + 1)'(LOW_DEPTH)) : LOW'(ltail_sum);

  // Lowest matching table slot wins.
  always_comb begin
    enc_slot  = '0;
    enc_found = |match_r;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        enc_slot = TW'(i);
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (cur_r.op)
          OP_DEQ: begin
            if (!deq_empty) begin
              state_nxt = ST_DQRD;
            end else if (out_free) begin
              state_nxt = ST_IDLE;
            end
          end
          OP_SET, OP_QRY: state_nxt = ST_MATCH;
          default: begin
            if (out_free) begin
              state_nxt = ST_IDLE;
            end
          end
        endcase
      end
      ST_DQRD:  state_nxt = ST_MATCH;
      ST_MATCH: state_nxt = ST_ENC;
      ST_ENC:   state_nxt = ST_RMW;
      ST_RMW: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Step controls and the result built in each step.
  always_comb begin
    pop         = 1'b0;
    do_enq      = 1'b0;
    do_deq_rd   = 1'b0;
    do_stop     = 1'b0;
    do_load_out = 1'b0;
    do_rmw_wr   = 1'b0;
    rsp_new     = '0;
    rsp_new.status = RSP_FAIL;
    set_st      = cur_r.new_state;
    set_res     = cur_r.new_result;
    if (cur_r.op == OP_DEQ) begin
      set_st  = JS_RUNNING;
      set_res = '0;
    end
    case (state_r)
      ST_IDLE: pop = !q_stat.empty;
      ST_DECODE: begin
        case (cur_r.op)
          OP_ENQ: begin
            do_enq      = out_free;
            do_load_out = out_free;
            if (!enq_stopped && !enq_full) begin
              rsp_new.status = RSP_OK;
              rsp_new.op_id  = enq_id;
            end
          end
          OP_DEQ: begin
            do_deq_rd   = !deq_empty;
            do_load_out = deq_empty && out_free;
            rsp_new.status = stop_r[li] ? RSP_FAIL : RSP_EMPTY;
          end
          OP_STOP: begin
            do_stop     = out_free;
            do_load_out = out_free;
            rsp_new.status = RSP_OK;
          end
          OP_SET, OP_QRY: ;
          default: do_load_out = out_free;
        endcase
      end
      ST_RMW: begin
        do_load_out = out_free;
        do_rmw_wr   = out_free && found_r && (cur_r.op != OP_QRY);
        case (cur_r.op)
          OP_DEQ: begin
            rsp_new.status  = RSP_OK;
            rsp_new.op_id   = word_r.id;
            rsp_new.lane    = cur_r.lane;
            rsp_new.unit    = word_r.unit;
            rsp_new.command = word_r.command;
          end
          OP_QRY: begin
            if (found_r) begin
              rsp_new.status     = RSP_OK;
              rsp_new.op_id      = key_r;
              rsp_new.lane       = trd_r.lane;
              rsp_new.unit       = trd_r.unit;
              rsp_new.command    = trd_r.command;
              rsp_new.state      = trd_r.state;
              rsp_new.result     = trd_r.result;
              rsp_new.created_ms = trd_r.created_ms;
              rsp_new.started_ms = trd_r.started_ms;
              rsp_new.ended_ms   = trd_r.ended_ms;
            end
          end
          default: rsp_new.status = found_r ? RSP_OK : RSP_FAIL;
        endcase
      end
      default: ;
    endcase
  end

  // Table write: a fresh entry on enqueue, a state update after a set-state or dequeue lookup that found its id.
  always_comb begin
    tab_we = 1'b0;
    tab_wa = slot_r;
    tab_wd = trd_r;
    if (do_enq) begin
      tab_we            = 1'b1;
      tab_wa            = ins_r;
      tab_wd.lane       = cur_r.lane;
      tab_wd.unit       = cur_r.unit;
      tab_wd.command    = cur_r.command;
      tab_wd.created_ms = cur_r.now_ms;
      tab_wd.started_ms = '0;
      if (enq_stopped || enq_full) begin
        tab_wd.state    = enq_stopped ? JS_CANCELED : JS_FAILED;
        tab_wd.result   = RESULT_FAIL;
        tab_wd.ended_ms = cur_r.now_ms;
      end else begin
        tab_wd.state    = JS_QUEUED;
        tab_wd.result   = '0;
        tab_wd.ended_ms = '0;
      end
    end else if (do_rmw_wr) begin
      tab_we        = 1'b1;
      tab_wd.state  = set_st;
      tab_wd.result = set_res;
      if (set_st == JS_RUNNING && trd_r.started_ms == '0) begin
        tab_wd.started_ms = cur_r.now_ms;
      end
      if ((set_st == JS_DONE || set_st == JS_FAILED || set_st == JS_CANCELED)
          && trd_r.ended_ms == '0) begin
        tab_wd.ended_ms = cur_r.now_ms;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      next_id_r   <= 32'd1;
      ins_r       <= '0;
      for (int i = 0; i < LANE_COUNT; i++) begin
        hhead_r[i] <= '0;
        hcnt_r[i]  <= '0;
        lhead_r[i] <= '0;
        lcnt_r[i]  <= '0;
        stop_r[i]  <= 1'b0;
      end
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        idv_r[i] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      if (do_load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (do_stop) begin
        stop_r[li] <= 1'b1;
      end
      if (do_enq) begin
        next_id_r    <= enq_id + 32'd1;
        ins_r        <= (ins_r == TW'(TABLE_DEPTH - 1)) ? '0 : ins_r + 1'b1;
        idv_r[ins_r] <= 1'b1;
        if (!enq_stopped && !enq_full) begin
          if (cur_r.prio) begin
            hcnt_r[li] <= hcnt_r[li] + 1'b1;
          end else begin
            lcnt_r[li] <= lcnt_r[li] + 1'b1;
          end
        end
      end
      if (do_deq_rd) begin
        if (hcnt_r[li] != '0) begin
          hhead_r[li] <= (hhead_r[li] == HW'(HIGH_DEPTH - 1)) ? '0 : hhead_r[li] + 1'b1;
          hcnt_r[li]  <= hcnt_r[li] - 1'b1;
        end else begin
          lhead_r[li] <= (lhead_r[li] == LOW'(LOW_DEPTH - 1)) ? '0 : lhead_r[li] + 1'b1;
          lcnt_r[li]  <= lcnt_r[li] - 1'b1;
        end
      end
    end
  end

  // Item, key, match vector and result payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= pop_cmd;
    end
    if (do_deq_rd) begin
      from_hi_r <= (hcnt_r[li] != '0);
    end
    if (state_r == ST_DECODE) begin
      key_r <= cur_r.op_id;
    end
    if (state_r == ST_DQRD) begin
      word_r <= from_hi_r ? hrd_r : lrd_r;
      key_r  <= from_hi_r ? hrd_r.id : lrd_r.id;
    end
    if (state_r == ST_MATCH) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        match_r[i] <= idv_r[i] && (ids_r[i] == key_r) && (key_r != '0);
      end
    end
    if (state_r == ST_ENC) begin
      slot_r  <= enc_slot;
      found_r <= enc_found;
    end
    if (do_load_out) begin
      out_rsp_r <= rsp_new;
    end
    if (do_enq) begin
      ids_r[ins_r] <= enq_id;
    end
  end

  // High FIFO memory.
  always_ff @(posedge clk) begin
    if (do_enq && cur_r.prio && !enq_stopped && !enq_full) begin
      hmem[{li, htail}] <= '{id: enq_id, unit: cur_r.unit, command: cur_r.command};
    end
    hrd_r <= hmem[{li, hhead_r[li]}];
  end

  // Low FIFO memory.
  always_ff @(posedge clk) begin
    if (do_enq && !cur_r.prio && !enq_stopped && !enq_full) begin
      lmem[{li, ltail}] <= '{id: enq_id, unit: cur_r.unit, command: cur_r.command};
    end
    lrd_r <= lmem[{li, lhead_r[li]}];
  end

  // Status table memory.
  always_ff @(posedge clk) begin
    if (tab_we) begin
      tmem[tab_wa] <= tab_wd;
    end
    trd_r <= tmem[enc_slot];
  end

endmodule

// ===== hdl/lane_priority_job_queue_core.sv =====
// Lane job queue with a high and a low priority ring per lane and a job status table.
// Input channel in_*: one request per transfer (enqueue, dequeue, set state, query,
// stop lane). Result channel out_*: exactly one result per request, in order.
// Both channels use valid and stall; a transfer happens when valid is high and
// stall is low. A two-entry command queue parts the accepting front end from the
// executing back end, and a result register parts the back end from the receiver.
// Enqueue, stop and rejected requests pass IDLE and DECODE; set state and query pass
// IDLE, DECODE, id compare, slot encode and table read-modify-write; a dequeue adds a
// FIFO read after DECODE, or ends in DECODE when both rings of its lane are empty.
// The single back-end sequencer, with its one table port, takes one request at a time.
// While the receiver stalls, the result holds, the back end waits on its final step
// and the input stalls once the command queue is full.
// Synchronous reset empties all rings, clears the stop flags and table ids, sets the
// next id to 1 and the insert slot to 0; no clearing pass is needed.
module lane_priority_job_queue_core #(
  parameter int unsigned LANE_COUNT  = 4,
  parameter int unsigned HIGH_DEPTH  = 8,
  parameter int unsigned LOW_DEPTH   = 16,
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_mode,
  input  logic [2:0]         in_lane,
  input  logic               in_prio,
  input  logic [7:0]         in_unit,
  input  logic [7:0]         in_command,
  input  logic [31:0]        in_op_id,
  input  logic [2:0]         in_new_state,
  input  logic signed [31:0] in_new_result,
  input  logic [31:0]        in_now_ms,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [31:0]        out_op_id,
  output logic [2:0]         out_lane,
  output logic [7:0]         out_unit,
  output logic [7:0]         out_command,
  output logic [2:0]         out_state,
  output logic signed [31:0] out_result,
  output logic [31:0]        out_created_ms,
  output logic [31:0]        out_started_ms,
  output logic [31:0]        out_ended_ms
);
  import lpjq_pkg::*;

  q_stat_t q_stat;
  cmd_t    push_cmd, pop_cmd;
  logic    push, pop;
  rsp_t    rsp;

  lpjq_front #(.LANE_COUNT(LANE_COUNT)) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_lane       (in_lane),
    .in_prio       (in_prio),
    .in_unit       (in_unit),
    .in_command    (in_command),
    .in_op_id      (in_op_id),
    .in_new_state  (in_new_state),
    .in_new_result (in_new_result),
    .in_now_ms     (in_now_ms),
    .q_stat        (q_stat),
    .push          (push),
    .push_cmd      (push_cmd)
  );

  lpjq_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_stat   (q_stat)
  );

  lpjq_back #(
    .LANE_COUNT  (LANE_COUNT),
    .HIGH_DEPTH  (HIGH_DEPTH),
    .LOW_DEPTH   (LOW_DEPTH),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (rsp)
  );

  // Result fields.
  assign out_status     = rsp.status;
  assign out_op_id      = rsp.op_id;
  assign out_lane       = rsp.lane;
  assign out_unit       = rsp.unit;
  assign out_command    = rsp.command;
  assign out_state      = rsp.state;
  assign out_result     = rsp.result;
  assign out_created_ms = rsp.created_ms;
  assign out_started_ms = rsp.started_ms;
  assign out_ended_ms   = rsp.ended_ms;

endmodule

// ===== hdl/lpjq_checker.sv =====
`include "lane_priority_job_queue_core_defines.svh"

module lpjq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [31:0] out_op_id,
  input logic [2:0]  out_lane,
  input logic [31:0] out_started_ms
);
  import lpjq_pkg::*;

  // A stalled result stays offered.
  `LPJQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

  // Only the three defined status codes appear.
  `LPJQ_ASSERT_NOW(a_status_code, clk, rst_n, out_valid,
    out_status == RSP_OK || out_status == RSP_FAIL || out_status == RSP_EMPTY)

  // A failed or empty result carries no job id.
  `LPJQ_ASSERT_NOW(a_fail_no_id, clk, rst_n, out_valid && out_status != RSP_OK,
    out_op_id == '0 && out_lane == '0)

  // Timestamps only come with a successful query.
  `LPJQ_ASSERT_NOW(a_stamp_ok, clk, rst_n, out_valid && out_started_ms != '0,
    out_status == RSP_OK)

endmodule

bind lane_priority_job_queue_core lpjq_checker u_lpjq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_op_id      (out_op_id),
  .out_lane       (out_lane),
  .out_started_ms (out_started_ms)
);
